/* rtl/ftwp_pkg.sv */
// ----------------------------------------------------------------------------
// ftwp_pkg
// Shared types and constants for the frame time window percentile block.
// ----------------------------------------------------------------------------
package ftwp_pkg;

   localparam int TIME_W    = 24;
   localparam int PCT_W     = 17;
   localparam int OVR_W     = 32;
   localparam int CNT_OUT_W = 8;
   localparam int BIT_W     = 5;

   localparam logic [PCT_W-1:0]  Q16_ONE       = 17'h10000;
   localparam logic [TIME_W-1:0] BUDGET_RESET  = 24'd16667;
   localparam logic [BIT_W-1:0]  TOP_BIT       = 5'd23;

   typedef enum logic [1:0] {
      OP_RECORD = 2'd0,
      OP_QUERY  = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TAIL,
      ST_DECIDE,
      ST_EMIT
   } state_type;

endpackage

/* rtl/frame_time_window_percentile_top.sv */
// Record, clear and unused-op transactions go straight to the emit state; a query
// of a non-empty ring runs the radix select first (an empty ring goes straight too).
// Throughput: one transaction at a time; the query time is set by a radix select
// that walks all stored entries once per result bit through the single RAM read port.
// Reset: synchronous; clears pointer, entry count, overrun counter and budget to 16667.
// History RAM is not cleared; only entries written since the last clear are read.
// ----------------------------------------------------------------------------
// frame_time_window_percentile_top
// Ring of slowest frame stage times with overrun counting and percentile query.
// ----------------------------------------------------------------------------
module frame_time_window_percentile_top
   import ftwp_pkg::*;
#(
   parameter int CAPACITY = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [TIME_W-1:0]     req_ui_time,
   input  logic [TIME_W-1:0]     req_compositor_time,
   input  logic [TIME_W-1:0]     req_gpu_time,
   input  logic [PCT_W-1:0]      req_percentile,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_frame_late,
   output logic [OVR_W-1:0]      rsp_overrun_total,
   output logic [CNT_OUT_W-1:0]  rsp_stored_count,
   output logic [TIME_W-1:0]     rsp_percentile_value,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = PCT_W + CW;

   // ---------------------------------------------------------------- state
   state_type         state_ff, state_in;

   logic [TIME_W-1:0] budget_ff, budget_in;
   logic [AW-1:0]     wptr_ff, wptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [OVR_W-1:0]  overrun_ff, overrun_in;

   logic [AW-1:0]     raddr_ff, raddr_in;
   logic              rd_vld_ff;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [CW-1:0]     rank_ff, rank_in;
   logic [CW-1:0]     zeros_ff, zeros_in;
   logic [TIME_W-1:0] prefix_ff, prefix_in;

   logic              pend_late_ff, pend_late_in;
   logic [TIME_W-1:0] pend_value_ff, pend_value_in;

   logic              rsp_valid_ff;
   logic              rsp_late_ff;
   logic [OVR_W-1:0]  rsp_overrun_ff;
   logic [CNT_OUT_W-1:0] rsp_count_ff;
   logic [TIME_W-1:0] rsp_value_ff;

   // ------------------------------------------------------- control outputs
   logic              accept;
   logic              ram_re;
   logic              load_rsp;
   logic              last_issue;
   logic              out_free;

   // -------------------------------------------------------------- datapath
   logic [TIME_W-1:0] slowest;
   logic [PCT_W-1:0]  pct_clamped;
   logic [PW-1:0]     rank_prod;
   logic [TIME_W-1:0] rdata;
   logic [TIME_W-1:0] mask_hi;
   logic              hit_zero;
   logic              ram_we;
   logic              csr_wr;

   // ------------------------------------------------------- history memory
   ftwp_ram #(
      .WIDTH (TIME_W),
      .DEPTH (CAPACITY)
   ) u_hist (
      .clock (clock),
      .we    (ram_we),
      .waddr (wptr_ff),
      .wdata (slowest),
      .re    (ram_re),
      .raddr (raddr_ff),
      .rdata (rdata)
   );

   // ------------------------------------------------------- configuration
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];
   assign budget_in  = csr_wr ? csr_pwdata[TIME_W-1:0] : budget_ff;

   always_comb begin
      csr_prdata = '0;
      if (!csr_paddr[2]) begin
         csr_prdata = {{(32-TIME_W){1'b0}}, budget_ff};
      end
   end

   // ------------------------------------------------------------ next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (op_type'(req_op) == OP_QUERY && count_ff != '0) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SCAN: begin
            if (last_issue) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (bit_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // --------------------------------------------------------------- outputs
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign last_issue = (CW'(raddr_ff) + CW'(1)) == count_ff;

   always_comb begin
      req_ready = 1'b0;
      ram_re    = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   ram_re    = 1'b1;
         ST_EMIT:   load_rsp  = out_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   // ------------------------------------------------------ record / clear
   always_comb begin
      slowest = req_ui_time;
      if (req_compositor_time > slowest) slowest = req_compositor_time;
      if (req_gpu_time > slowest)        slowest = req_gpu_time;
   end

   assign ram_we = accept && op_type'(req_op) == OP_RECORD;

   always_comb begin
      wptr_in       = wptr_ff;
      count_in      = count_ff;
      overrun_in    = overrun_ff;
      pend_late_in  = pend_late_ff;
      if (accept) begin
         pend_late_in = 1'b0;
         case (op_type'(req_op))
            OP_RECORD: begin
               wptr_in = (wptr_ff == AW'(CAPACITY - 1)) ? '0 : wptr_ff + AW'(1);
               if (count_ff != CW'(CAPACITY)) begin
                  count_in = count_ff + CW'(1);
               end
               if (slowest > budget_ff) begin
                  pend_late_in = 1'b1;
                  if (overrun_ff != '1) begin
                     overrun_in = overrun_ff + OVR_W'(1);
                  end
               end
            end
            OP_CLEAR: begin
               wptr_in    = '0;
               count_in   = '0;
               overrun_in = '0;
            end
            default: begin
               wptr_in = wptr_ff;
            end
         endcase
      end
   end

   // ------------------------------------------------------- radix select
   assign pct_clamped = (req_percentile > Q16_ONE) ? Q16_ONE : req_percentile;
   assign rank_prod   = PW'(pct_clamped) * PW'(count_ff - CW'(1));

   always_comb begin
      mask_hi  = {TIME_W{1'b1}} << ({1'b0, bit_ff} + 6'd1);
      hit_zero = (((rdata ^ prefix_ff) & mask_hi) == '0) && !rdata[bit_ff];
   end

   always_comb begin
      raddr_in      = raddr_ff;
      bit_in        = bit_ff;
      rank_in       = rank_ff;
      zeros_in      = zeros_ff;
      prefix_in     = prefix_ff;
      pend_value_in = pend_value_ff;

      if (rd_vld_ff && hit_zero) begin
         zeros_in = zeros_ff + CW'(1);
      end
      if (ram_re) begin
         raddr_in = last_issue ? '0 : raddr_ff + AW'(1);
      end

      if (accept) begin
         raddr_in      = '0;
         bit_in        = TOP_BIT;
         rank_in       = rank_prod[16 +: CW];
         zeros_in      = '0;
         prefix_in     = '0;
         pend_value_in = '0;
      end else if (state_ff == ST_DECIDE) begin
         // rank falls among entries with a zero here, or skip them and take a one
         zeros_in = '0;
         if (rank_ff >= zeros_ff) begin
            rank_in   = rank_ff - zeros_ff;
            prefix_in = prefix_ff | (TIME_W'(1) << bit_ff);
         end
         if (bit_ff == '0) begin
            pend_value_in = prefix_in;
         end else begin
            bit_in = bit_ff - BIT_W'(1);
         end
      end
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         budget_ff    <= BUDGET_RESET;
         wptr_ff      <= '0;
         count_ff     <= '0;
         overrun_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         budget_ff    <= budget_in;
         wptr_ff      <= wptr_in;
         count_ff     <= count_in;
         overrun_ff   <= overrun_in;
         rd_vld_ff    <= ram_re;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      raddr_ff      <= raddr_in;
      bit_ff        <= bit_in;
      rank_ff       <= rank_in;
      zeros_ff      <= zeros_in;
      prefix_ff     <= prefix_in;
      pend_late_ff  <= pend_late_in;
      pend_value_ff <= pend_value_in;
      if (load_rsp) begin
         rsp_late_ff    <= pend_late_ff;
         rsp_overrun_ff <= overrun_ff;
         rsp_count_ff   <= CNT_OUT_W'(count_ff);
         rsp_value_ff   <= pend_value_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_frame_late       = rsp_late_ff;
   assign rsp_overrun_total    = rsp_overrun_ff;
   assign rsp_stored_count     = rsp_count_ff;
   assign rsp_percentile_value = rsp_value_ff;

endmodule

/* rtl/ftwp_ram.sv */
// ----------------------------------------------------------------------------
// ftwp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ftwp_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
